FILE: hw/rtl/pesp_pkg.sv
package pesp_pkg;

	// command kinds passed from the front end to the byte sequencer
	localparam logic [1:0] CMD_ERR = 2'd0;  // one error word, nothing else
	localparam logic [1:0] CMD_PAY = 2'd1;  // one payload word
	localparam logic [1:0] CMD_HDR = 2'd2;  // packet header words, then one payload word

	// error codes carried on error_code
	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_DTS   = 2'd1;
	localparam logic [1:0] ERR_LEN   = 2'd2;
	localparam logic [1:0] ERR_MAXSZ = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_STREAM_ID  = 2'd0;
	localparam logic [1:0] REG_SPLIT      = 2'd1;
	localparam logic [1:0] REG_MAX_PACKET = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  err;
		logic [7:0]  data;
		logic        last;
		logic [7:0]  sid;
		logic [15:0] len;
		logic        opt;
		logic        al;
		logic        p;
		logic        d;
		logic [32:0] pts;
		logic [32:0] dts;
	} cmd_t;

endpackage

FILE: hw/rtl/pesp_front.sv
module pesp_front #(
	parameter int UNIT_SIZE_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [15:0]               cfg_data,
	input  logic                      push,
	output logic                      full,
	input  logic [7:0]                data_byte,
	input  logic                      unit_start,
	input  logic [UNIT_SIZE_BITS-1:0] unit_size,
	input  logic [32:0]               pts_value,
	input  logic [32:0]               dts_value,
	input  logic                      pts_present,
	input  logic                      dts_present,
	input  logic                      align_flag,
	input  logic                      q_full,
	output logic                      q_push,
	output pesp_pkg::cmd_t            q_cmd
);

	localparam int U = UNIT_SIZE_BITS;

	function automatic logic has_opt(input logic [7:0] sid);
		has_opt = !(sid == 8'hBC || sid == 8'hBF || sid == 8'hF0 || sid == 8'hF1 ||
			sid == 8'hF2 || sid == 8'hF8 || sid == 8'hFF);
	endfunction

	logic [7:0]  sid_q;
	logic        split_q;
	logic [15:0] mps_q;

	logic [U-1:0] ubl_q;
	logic [15:0]  cbl_q;
	logic         first_q;
	logic         drop_q;
	logic [15:0]  cpm_q;
	logic [32:0]  pts_q;
	logic [32:0]  dts_q;
	logic [2:0]   flags_q;

	logic [U-1:0] e_ubl, n_ubl, chunk;
	logic [15:0]  e_cbl, n_cbl, cbl_w, e_cpm, n_cpm;
	logic         e_first, n_first, e_drop, n_drop;
	logic [32:0]  e_pts, e_dts;
	logic [2:0]   e_flags;
	logic         acc, p_in, d_in, opt, video, hdr, cpm_on, p2, d2;
	logic [3:0]   ts_in, ts2;
	logic [4:0]   extra_in, extra2;
	logic [U:0]   len_chk;
	logic [1:0]   err;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sid_q   <= 8'hE0;
			split_q <= 1'b0;
			mps_q   <= 16'd184;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pesp_pkg::REG_STREAM_ID:  sid_q   <= cfg_data[7:0];
				pesp_pkg::REG_SPLIT:      split_q <= cfg_data[0];
				pesp_pkg::REG_MAX_PACKET: mps_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		acc      = push && !q_full;
		p_in     = pts_present;
		d_in     = pts_present && dts_present;
		ts_in    = d_in ? 4'd10 : (p_in ? 4'd5 : 4'd0);
		opt      = has_opt(sid_q);
		video    = (sid_q[7:4] == 4'hE);
		extra_in = opt ? 5'd3 + {1'b0, ts_in} : 5'd0;
		len_chk  = {1'b0, unit_size} + (U+1)'(extra_in);
		err      = pesp_pkg::ERR_OK;
		priority if (split_q && mps_q < 16'd10 + {12'd0, ts_in}) err = pesp_pkg::ERR_MAXSZ;
		else if (d_in && dts_value > pts_value) err = pesp_pkg::ERR_DTS;
		else if (!split_q && !video && len_chk > (U+1)'(65535)) err = pesp_pkg::ERR_LEN;

		e_ubl   = ubl_q;
		e_cbl   = cbl_q;
		e_first = first_q;
		e_drop  = drop_q;
		e_cpm   = cpm_q;
		e_pts   = pts_q;
		e_dts   = dts_q;
		e_flags = flags_q;
		q_push  = 1'b0;
		q_cmd   = '0;

		// a unit start abandons whatever was in progress
		if (unit_start) begin
			e_ubl   = unit_size;
			e_cbl   = 16'd0;
			e_drop  = 1'b0;
			e_first = 1'b1;
			e_cpm   = 16'd0;
			if (unit_size != '0) begin
				if (err != pesp_pkg::ERR_OK) begin
					q_push     = acc;
					q_cmd.kind = pesp_pkg::CMD_ERR;
					q_cmd.err  = err;
					e_drop     = 1'b1;
				end else begin
					e_cpm   = split_q ? mps_q - 16'd9 - {12'd0, ts_in} : 16'd0;
					e_pts   = pts_value;
					e_dts   = dts_value;
					e_flags = {align_flag, d_in, p_in};
				end
			end
		end

		cpm_on  = (e_cpm != 16'd0);
		hdr     = e_first || (cpm_on && e_cbl == 16'd0);
		chunk   = (cpm_on && e_ubl > U'(e_cpm)) ? U'(e_cpm) : e_ubl;
		p2      = e_first && e_flags[0];
		d2      = p2 && e_flags[1];
		ts2     = d2 ? 4'd10 : (p2 ? 4'd5 : 4'd0);
		extra2  = opt ? 5'd3 + {1'b0, ts2} : 5'd0;
		cbl_w   = e_cbl;
		n_ubl   = e_ubl;
		n_cbl   = e_cbl;
		n_first = e_first;
		n_drop  = e_drop;
		n_cpm   = e_cpm;

		if (e_ubl == '0) begin
			n_drop = 1'b0;
		end else if (e_drop) begin
			// swallow the bytes of a rejected unit
			n_ubl  = e_ubl - U'(1);
			n_drop = (n_ubl != '0);
		end else begin
			if (hdr) begin
				cbl_w   = cpm_on ? chunk[15:0] : 16'd0;
				n_first = 1'b0;
			end
			n_ubl = e_ubl - U'(1);
			n_cbl = (cpm_on && cbl_w != 16'd0) ? cbl_w - 16'd1 : cbl_w;
			q_push     = acc;
			q_cmd.kind = hdr ? pesp_pkg::CMD_HDR : pesp_pkg::CMD_PAY;
			q_cmd.data = data_byte;
			q_cmd.last = (n_ubl == '0) || (cpm_on && n_cbl == 16'd0);
			q_cmd.sid  = sid_q;
			q_cmd.len  = video ? 16'd0 : {11'd0, extra2} + chunk[15:0];
			q_cmd.opt  = opt;
			q_cmd.al   = e_first && e_flags[2];
			q_cmd.p    = p2;
			q_cmd.d    = d2;
			q_cmd.pts  = e_pts;
			q_cmd.dts  = e_dts;
			if (n_ubl == '0) begin
				n_cbl   = 16'd0;
				n_cpm   = 16'd0;
				n_first = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ubl_q   <= '0;
			cbl_q   <= 16'd0;
			first_q <= 1'b1;
			drop_q  <= 1'b0;
			cpm_q   <= 16'd0;
			pts_q   <= 33'd0;
			dts_q   <= 33'd0;
			flags_q <= 3'd0;
		end else if (acc) begin
			ubl_q   <= n_ubl;
			cbl_q   <= n_cbl;
			first_q <= n_first;
			drop_q  <= n_drop;
			cpm_q   <= n_cpm;
			pts_q   <= e_pts;
			dts_q   <= e_dts;
			flags_q <= e_flags;
		end
	end

endmodule

FILE: hw/rtl/pesp_cmdq.sv
module pesp_cmdq #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  pesp_pkg::cmd_t wr_cmd,
	output logic           q_full,
	input  logic           rd_en,
	output pesp_pkg::cmd_t rd_cmd,
	output logic           q_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pesp_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  cnt_q;
	logic           do_wr, do_rd;

	assign q_full  = (cnt_q == CW'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_cmd  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (do_rd) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			if (do_wr && !do_rd) cnt_q <= cnt_q + CW'(1);
			else if (do_rd && !do_wr) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

FILE: hw/rtl/pesp_back.sv
module pesp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pesp_pkg::cmd_t cmd,
	input  logic           q_empty,
	output logic           q_pop,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     out_byte,
	output logic           packet_first,
	output logic           packet_last,
	output logic           run_last,
	output logic [1:0]     error_code
);

	// header word at position idx, start code through the last timestamp word
	function automatic logic [7:0] hdr_byte(input pesp_pkg::cmd_t c, input logic [4:0] idx);
		logic [32:0] t;
		logic [3:0]  m;
		logic [4:0]  j;
		logic [7:0]  tb;
		if (idx < 5'd14) begin
			t = c.pts;
			m = c.d ? 4'h3 : 4'h2;
			j = idx - 5'd9;
		end else begin
			t = c.dts;
			m = 4'h1;
			j = idx - 5'd14;
		end
		unique case (j)
			5'd0:    tb = {m, t[32:30], 1'b1};
			5'd1:    tb = t[29:22];
			5'd2:    tb = {t[21:15], 1'b1};
			5'd3:    tb = t[14:7];
			5'd4:    tb = {t[6:0], 1'b1};
			default: tb = 8'h00;
		endcase
		unique case (idx)
			5'd0, 5'd1: hdr_byte = 8'h00;
			5'd2:       hdr_byte = 8'h01;
			5'd3:       hdr_byte = c.sid;
			5'd4:       hdr_byte = c.len[15:8];
			5'd5:       hdr_byte = c.len[7:0];
			5'd6:       hdr_byte = {5'b10000, c.al, 2'b00};
			5'd7:       hdr_byte = c.d ? 8'hC0 : (c.p ? 8'h80 : 8'h00);
			5'd8:       hdr_byte = c.d ? 8'd10 : (c.p ? 8'd5 : 8'd0);
			default:    hdr_byte = tb;
		endcase
	endfunction

	logic [4:0] cnt_q, hcnt;
	logic       ov_q, adv, fire, fin;
	logic [7:0] ob_q, nb;
	logic       pf_q, pl_q, rl_q, npf, npl;
	logic [1:0] ec_q, nec;

	always_comb begin
		adv  = !ov_q || pop;
		fire = adv && !q_empty;
		hcnt = cmd.opt ? (cmd.d ? 5'd19 : (cmd.p ? 5'd14 : 5'd9)) : 5'd6;
		fin  = (cmd.kind != pesp_pkg::CMD_HDR) || (cnt_q == hcnt);
		nb   = 8'h00;
		npf  = 1'b0;
		npl  = 1'b0;
		nec  = pesp_pkg::ERR_OK;
		unique case (cmd.kind)
			pesp_pkg::CMD_ERR: nec = cmd.err;
			pesp_pkg::CMD_PAY: begin
				nb  = cmd.data;
				npl = cmd.last;
			end
			pesp_pkg::CMD_HDR: begin
				if (cnt_q == hcnt) begin
					nb  = cmd.data;
					npl = cmd.last;
				end else begin
					nb  = hdr_byte(cmd, cnt_q);
					npf = (cnt_q == 5'd0);
				end
			end
			default: ;
		endcase
	end

	assign q_pop = fire && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			cnt_q <= 5'd0;
		end else begin
			if (adv) ov_q <= fire;
			if (fire) cnt_q <= fin ? 5'd0 : cnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ob_q <= nb;
			pf_q <= npf;
			pl_q <= npl;
			rl_q <= fin;
			ec_q <= nec;
		end
	end

	assign empty        = !ov_q;
	assign out_byte     = ob_q;
	assign packet_first = pf_q;
	assign packet_last  = pl_q;
	assign run_last     = rl_q;
	assign error_code   = ec_q;

endmodule

FILE: hw/rtl/pes_packetizer.sv
// PES packetizer. Elementary-stream bytes go in one word per push; PES words come out one
// per pop. The front end takes one input word every cycle while its command queue has room,
// checks and classifies it, and queues at most one command; the sequencer behind the queue
// sends one output word per cycle while the output register is free or popped. A payload
// word gives one output word. A word that opens a packet gives 7 output words for stream ids
// without optional fields, and 10, 15 or 20 with optional fields and no, PTS-only or PTS+DTS
// timestamps; the queue (CMDQ_DEPTH commands) lets input words keep arriving while a header
// drains, so full rises only when headers come faster than the sequencer can clear them or
// pop is held low. A rejected unit gives one error word, after which its bytes are dropped,
// one per cycle while the queue has room. Configuration writes are always ready
// and are meant to arrive while the block is idle.
module pes_packetizer #(
	parameter int UNIT_SIZE_BITS = 24,
	parameter int CMDQ_DEPTH     = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [15:0]               cfg_data,
	input  logic                      push,
	output logic                      full,
	input  logic [7:0]                data_byte,
	input  logic                      unit_start,
	input  logic [UNIT_SIZE_BITS-1:0] unit_size,
	input  logic [32:0]               pts_value,
	input  logic [32:0]               dts_value,
	input  logic                      pts_present,
	input  logic                      dts_present,
	input  logic                      align_flag,
	output logic                      empty,
	input  logic                      pop,
	output logic [7:0]                out_byte,
	output logic                      packet_first,
	output logic                      packet_last,
	output logic                      run_last,
	output logic [1:0]                error_code
);

	pesp_pkg::cmd_t wr_cmd, rd_cmd;
	logic           q_push, q_full, q_pop, q_empty;

	// classify each input word and hold the unit and chunk counters
	pesp_front #(
		.UNIT_SIZE_BITS(UNIT_SIZE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.unit_start  (unit_start),
		.unit_size   (unit_size),
		.pts_value   (pts_value),
		.dts_value   (dts_value),
		.pts_present (pts_present),
		.dts_present (dts_present),
		.align_flag  (align_flag),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (wr_cmd)
	);

	// decouple the two sides so a header burst does not stall the input at once
	pesp_cmdq #(
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_cmd  (wr_cmd),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_cmd  (rd_cmd),
		.q_empty (q_empty)
	);

	// expand each command into output words in the output register, one per cycle unless held by pop
	pesp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (rd_cmd),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.packet_first (packet_first),
		.packet_last  (packet_last),
		.run_last     (run_last),
		.error_code   (error_code)
	);

	// a payload word that closes a packet is always the last word of its input word
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && packet_last |-> run_last)
		else $error("packet_last without run_last");

	// an error word stands alone: zero data, no packet marks
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && error_code != pesp_pkg::ERR_OK |->
			run_last && out_byte == 8'h00 && !packet_first && !packet_last)
		else $error("malformed error word");

	// a packet opens with the first start-code word and never ends the run there
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && packet_first |-> out_byte == 8'h00 && !run_last && !packet_last)
		else $error("malformed packet start");

endmodule
